>>> rtl/core/rfd_pkg.sv
// rfd_pkg: shared types and constants for the rx frame deframer and decipher.
// Used by rfd_frame_ctrl, rfd_out_fifo and the top level; depends on nothing.
package rfd_pkg;

    // header is key byte plus 16-bit little-endian total length
    localparam logic [15:0] HEADER_LEN     = 16'd3;
    localparam logic [15:0] MAX_BODY_RESET = 16'd8192;

    // result status codes
    typedef enum logic [1:0] {
        ST_BODY  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_LARGE = 2'd2
    } status_t;

    // frame parser phases, one-hot
    typedef enum logic [3:0] {
        PH_KEY    = 4'b0001,
        PH_LEN_LO = 4'b0010,
        PH_LEN_HI = 4'b0100,
        PH_BODY   = 4'b1000
    } phase_t;

    // one result item
    typedef struct packed {
        status_t     status;
        logic [7:0]  data_byte;
        logic [7:0]  msg_key;
        logic [15:0] body_length;
        logic        last;
    } result_t;

endpackage

>>> rtl/core/rfd_in_if.sv
// rfd_in_if: valid/ready channel that carries raw received bytes.
// Standalone interface; no package dependency.
interface rfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

>>> rtl/core/rfd_out_if.sv
// rfd_out_if: valid/ready channel that carries deframed result items.
// Standalone interface; no package dependency.
interface rfd_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [7:0]  data_byte;
    logic [7:0]  msg_key;
    logic [15:0] body_length;
    logic        last;

    modport source (output valid, output status, output data_byte, output msg_key,
                    output body_length, output last, input ready);
    modport sink   (input valid, input status, input data_byte, input msg_key,
                    input body_length, input last, output ready);
endinterface

>>> rtl/core/rfd_decipher.sv
// rfd_decipher: combinational body byte decipher.
// Depends on nothing; used by rfd_frame_ctrl.
module rfd_decipher (
    input  logic [7:0] raw_byte,
    input  logic [7:0] key,
    input  logic [7:0] size_lo,
    input  logic [7:0] index_lo,
    output logic [7:0] plain_byte
);
    logic [7:0] mask;
    logic [7:0] mixed;
    logic [7:0] offset;

    // xor with key^(size-i), then subtract i^key, all mod 256; key 0 passes the byte through
    assign mask       = key ^ (size_lo - index_lo);
    assign mixed      = raw_byte ^ mask;
    assign offset     = index_lo ^ key;
    assign plain_byte = (key == 8'd0) ? raw_byte : (mixed - offset);

endmodule

>>> rtl/core/rfd_frame_ctrl.sv
// rfd_frame_ctrl: header parser, body counter and result formation.
// Depends on rfd_pkg and rfd_decipher.
module rfd_frame_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [7:0]        rx_byte,
    input  logic [15:0]       max_body_size,
    output logic              res_valid,
    output rfd_pkg::result_t  res
);
    import rfd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [7:0]  key_reg, key_next;
    logic [7:0]  len_low_reg, len_low_next;
    logic [15:0] size_reg, size_next;
    logic [15:0] index_reg, index_next;

    logic [15:0] total;
    logic [15:0] blen;
    logic        too_large;
    logic [16:0] index_inc;
    logic        last_hit;
    logic [7:0]  plain_byte;

    // header length decode
    assign total     = {rx_byte, len_low_reg};
    assign blen      = total - HEADER_LEN;
    assign too_large = (total < HEADER_LEN) || (blen > max_body_size);

    // body position
    assign index_inc = {1'b0, index_reg} + 17'd1;
    assign last_hit  = index_inc >= {1'b0, size_reg};

    rfd_decipher u_decipher (
        .raw_byte   (rx_byte),
        .key        (key_reg),
        .size_lo    (size_reg[7:0]),
        .index_lo   (index_reg[7:0]),
        .plain_byte (plain_byte)
    );

    // next state and result
    always_comb
    begin
        phase_next   = phase_reg;
        key_next     = key_reg;
        len_low_next = len_low_reg;
        size_next    = size_reg;
        index_next   = index_reg;
        res_valid    = 1'b0;
        res.status      = ST_BODY;
        res.data_byte   = 8'd0;
        res.msg_key     = key_reg;
        res.body_length = 16'd0;
        res.last        = 1'b0;
        if (fire)
        begin
            case (phase_reg)
                PH_KEY:
                begin
                    key_next    = rx_byte;
                    res.msg_key = rx_byte;
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    len_low_next = rx_byte;
                    phase_next   = PH_LEN_HI;
                end
                PH_LEN_HI:
                begin
                    size_next  = blen;
                    index_next = 16'd0;
                    if (total == HEADER_LEN)
                    begin
                        phase_next = PH_KEY;
                        res_valid  = 1'b1;
                        res.status = ST_EMPTY;
                    end
                    else if (too_large)
                    begin
                        phase_next      = PH_KEY;
                        res_valid       = 1'b1;
                        res.status      = ST_LARGE;
                        res.body_length = blen;
                    end
                    else
                    begin
                        phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    res_valid       = 1'b1;
                    res.status      = ST_BODY;
                    res.data_byte   = plain_byte;
                    res.body_length = size_reg;
                    res.last        = last_hit;
                    if (last_hit)
                    begin
                        phase_next = PH_KEY;
                        index_next = 16'd0;
                    end
                    else
                    begin
                        index_next = index_inc[15:0];
                    end
                end
                default:
                begin
                    phase_next = PH_KEY;
                    index_next = 16'd0;
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_KEY;
            key_reg     <= 8'd0;
            len_low_reg <= 8'd0;
            size_reg    <= 16'd0;
            index_reg   <= 16'd0;
        end
        else
        begin
            phase_reg   <= phase_next;
            key_reg     <= key_next;
            len_low_reg <= len_low_next;
            size_reg    <= size_next;
            index_reg   <= index_next;
        end
    end

    // header bytes before the length high byte never give a result
    a_no_result_early: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_KEY || phase_reg == PH_LEN_LO) |-> !res_valid)
        else $error("result produced on an early header byte");

    // final body byte sends the parser back to the key byte
    a_last_to_header: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res.last) |=> phase_reg == PH_KEY)
        else $error("parser did not return to header after last byte");

    // body index always stays inside the body
    a_index_in_body: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (index_reg < size_reg))
        else $error("body index ran past body size");

    // an empty frame reports zero length
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_EMPTY) |-> (res.body_length == 16'd0))
        else $error("empty status with nonzero length");

endmodule

>>> rtl/core/rfd_out_fifo.sv
// rfd_out_fifo: two-entry result buffer that decouples the output handshake.
// Depends on rfd_pkg.
module rfd_out_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rfd_pkg::result_t  push_data,
    output logic              not_full,
    output logic              out_valid,
    input  logic              out_ready,
    output rfd_pkg::result_t  out_data
);
    import rfd_pkg::*;

    logic [1:0] count_reg, count_next;
    result_t    slot0_reg, slot0_next;
    result_t    slot1_reg, slot1_next;
    logic       pop;

    assign not_full  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = slot0_reg;
    assign pop       = out_valid && out_ready;

    // slot update: head is always slot0
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        case (count_reg)
            2'd0:
            begin
                if (push)
                begin
                    slot0_next = push_data;
                    count_next = 2'd1;
                end
            end
            2'd1:
            begin
                if (push && pop)
                begin
                    slot0_next = push_data;
                end
                else if (push)
                begin
                    slot1_next = push_data;
                    count_next = 2'd2;
                end
                else if (pop)
                begin
                    count_next = 2'd0;
                end
            end
            2'd2:
            begin
                if (pop)
                begin
                    slot0_next = slot1_reg;
                    count_next = 2'd1;
                end
            end
            default:
            begin
                count_next = 2'd0;
            end
        endcase
    end

    // count under reset, payload free-running
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    // no push is ever presented while full
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> count_reg != 2'd2)
        else $error("push into full result buffer");

    // a waiting head item holds while not taken
    a_head_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && out_data == $past(out_data)))
        else $error("head item changed while stalled");

    // count never exceeds depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result buffer count out of range");

endmodule

>>> rtl/core/rx_frame_deframer_decipher.sv
// rx_frame_deframer_decipher: top level of the receive deframer and decipher.
// A result item is written into the result buffer as its byte is accepted and is offered from the buffer head.
// Throughput: one input byte per cycle while the result buffer is not full; header bytes and body bytes alike.
// A two-entry result buffer keeps input taking bytes while one result waits.
// Reset (rst_n low, async): parser back to key byte, buffer empty, max body 8192.
// Depends on rfd_pkg, rfd_in_if, rfd_out_if, rfd_frame_ctrl and rfd_out_fifo.
module rx_frame_deframer_decipher (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [15:0]  cfg_wdata,
    rfd_in_if.sink       rx_chan,
    rfd_out_if.source    msg_chan
);
    import rfd_pkg::*;

    logic [15:0] max_body_reg;
    logic        fire;
    logic        res_valid;
    result_t     res;
    logic        not_full;
    result_t     head;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_body_reg <= MAX_BODY_RESET;
        end
        else if (cfg_we)
        begin
            max_body_reg <= cfg_wdata;
        end
    end

    // input handshake
    assign rx_chan.ready = not_full;
    assign fire          = rx_chan.valid && not_full;

    rfd_frame_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .rx_byte       (rx_chan.rx_byte),
        .max_body_size (max_body_reg),
        .res_valid     (res_valid),
        .res           (res)
    );

    rfd_out_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .not_full  (not_full),
        .out_valid (msg_chan.valid),
        .out_ready (msg_chan.ready),
        .out_data  (head)
    );

    // output payload
    assign msg_chan.status      = head.status;
    assign msg_chan.data_byte   = head.data_byte;
    assign msg_chan.msg_key     = head.msg_key;
    assign msg_chan.body_length = head.body_length;
    assign msg_chan.last        = head.last;

endmodule
